FILE: src/fsk_correlator_bit_demodulator_unit_assert.svh
// Assertion macros for the FSK correlator bit demodulator.
// Included by the top level; the macros expand to nothing when SYNTHESIS is defined.
`ifndef FSK_CORRELATOR_BIT_DEMODULATOR_UNIT_ASSERT_SVH
`define FSK_CORRELATOR_BIT_DEMODULATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define FCBD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fcbd assertion failed");

`define FCBD_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define FCBD_ASSERT(label, prop)

`define FCBD_ASSERT_MSG(label, prop, msg)

`endif

`endif

FILE: src/fcbd_pkg.sv
// Shared types, constants and the tone coefficient table of the FSK demodulator.
// No dependencies.
package fcbd_pkg;

    localparam int MAX_BITS = 256;
    localparam int CNT_W    = $clog2(MAX_BITS + 1);
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
    localparam int ACC_W    = 33;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [7:0] PREAMBLE_RESET = 8'd32;
    localparam logic [2:0] SKIP_LAST      = 3'd1;
    localparam logic [2:0] WIN_LAST       = 3'd4;
    localparam logic       ADDR_PREAMBLE  = 1'b0;

    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CMP_W-1:0]        cmp_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [QPTR_W-1:0]       qptr_t;
    typedef logic [QPTR_W:0]         qcnt_t;

    // one decided window: up to two bits
    typedef struct packed {
        logic       has_a;
        logic       val_a;
        logic [7:0] idx_a;
        logic       has_b;
        logic       val_b;
        logic [7:0] idx_b;
    } job_t;

    typedef struct packed {
        logic full;
        logic valid;
    } qstat_t;

    // Q1.14 sine of k*pi/8; positions past the window end clamp to the last tap
    function automatic logic signed [15:0] sin_coeff(input logic [2:0] p);
        logic signed [15:0] c;
        begin
            case (p)
                3'd0:    c = 16'sd0;
                3'd1:    c = 16'sd6270;
                3'd2:    c = 16'sd11585;
                3'd3:    c = 16'sd15137;
                default: c = 16'sd16384;
            endcase
            return c;
        end
    endfunction

endpackage

FILE: src/fcbd_front.sv
// Front end: sample intake, window tracking, correlation and bit decision.
// Uses fcbd_pkg; pushes a job into the queue for each completed window that yields a bit.
module fcbd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic signed [15:0]  sample_q,
    input  logic                packet_end,
    input  logic [7:0]          preamble_bits,
    output logic                push,
    output fcbd_pkg::job_t      job
);

    logic [2:0]         wp_reg, wp_next;
    logic               skip_done_reg, skip_done_next;
    fcbd_pkg::acc_t     acc_reg, acc_next;
    fcbd_pkg::cnt_t     cnt_reg, cnt_next;
    logic               prev_reg, prev_next;

    logic signed [31:0] prod;
    fcbd_pkg::acc_t     dsum;
    logic               raw;
    fcbd_pkg::cmp_t     cnt_cmp;
    fcbd_pkg::cmp_t     pre_cmp;

    // plus minus tone difference reduces to the quadrature term only
    assign prod    = sample_q * fcbd_pkg::sin_coeff(wp_reg);
    assign dsum    = acc_reg + fcbd_pkg::acc_t'(prod);
    assign raw     = ~dsum[fcbd_pkg::ACC_W-1];
    assign cnt_cmp = fcbd_pkg::cmp_t'(cnt_reg);
    assign pre_cmp = fcbd_pkg::cmp_t'(preamble_bits);

    always_comb
    begin
        wp_next        = wp_reg;
        skip_done_next = skip_done_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        push           = 1'b0;
        job            = '0;
        if (accept)
        begin
            if (!skip_done_reg)
            begin
                if (wp_reg >= fcbd_pkg::SKIP_LAST)
                begin
                    skip_done_next = 1'b1;
                    wp_next        = 3'd0;
                end
                else
                begin
                    wp_next = wp_reg + 3'd1;
                end
            end
            else if (wp_reg >= fcbd_pkg::WIN_LAST)
            begin
                if (cnt_reg < fcbd_pkg::cnt_t'(fcbd_pkg::MAX_BITS))
                begin
                    job.has_a = (cnt_reg != '0) && ((cnt_cmp - 1'b1) < pre_cmp);
                    job.val_a = (prev_reg == raw);
                    job.idx_a = 8'(cnt_reg - 1'b1);
                    job.has_b = (cnt_cmp >= pre_cmp);
                    job.val_b = raw;
                    job.idx_b = 8'(cnt_reg);
                    push      = job.has_a | job.has_b;
                    prev_next = raw;
                    cnt_next  = cnt_reg + 1'b1;
                end
                acc_next = '0;
                wp_next  = 3'd1;
            end
            else
            begin
                acc_next = dsum;
                wp_next  = wp_reg + 3'd1;
            end
            if (packet_end)
            begin
                wp_next        = 3'd0;
                skip_done_next = 1'b0;
                acc_next       = '0;
                cnt_next       = '0;
                prev_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= 3'd0;
            skip_done_reg <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            prev_reg      <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            skip_done_reg <= skip_done_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
        end
    end

endmodule

FILE: src/fcbd_queue.sv
// Short job queue between the decision front end and the bit output stage.
// Uses fcbd_pkg for the job type and depth.
module fcbd_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fcbd_pkg::job_t     din,
    input  logic               pop,
    output fcbd_pkg::job_t     head,
    output fcbd_pkg::qstat_t   stat
);

    fcbd_pkg::job_t   mem_reg [fcbd_pkg::QDEPTH];
    fcbd_pkg::qptr_t  wr_reg, wr_next;
    fcbd_pkg::qptr_t  rd_reg, rd_next;
    fcbd_pkg::qcnt_t  cnt_reg, cnt_next;
    logic             do_pop;

    assign stat.full  = (cnt_reg == fcbd_pkg::qcnt_t'(fcbd_pkg::QDEPTH));
    assign stat.valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign do_pop     = pop & stat.valid;

    always_comb
    begin
        wr_next  = push   ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + fcbd_pkg::qcnt_t'(push) - fcbd_pkg::qcnt_t'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: src/fcbd_back.sv
// Output stage: turns queued jobs into single-bit requests on the master stream.
// Uses fcbd_pkg for the job and queue status types.
module fcbd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  fcbd_pkg::job_t     head,
    input  fcbd_pkg::qstat_t   stat,
    output logic               pop,
    output logic               out_valid,
    output logic               out_bit,
    output logic [7:0]         out_idx,
    output logic               out_last,
    input  logic               out_ready
);

    logic       valid_reg, valid_next;
    logic       bit_reg, bit_next;
    logic [7:0] idx_reg, idx_next;
    logic       last_reg, last_next;
    logic       pend_reg, pend_next;
    logic       pbit_reg, pbit_next;
    logic [7:0] pidx_reg, pidx_next;
    logic       adv;

    assign adv = ~valid_reg | out_ready;
    assign pop = adv & ~pend_reg & stat.valid;

    always_comb
    begin
        valid_next = valid_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        pend_next  = pend_reg;
        pbit_next  = pbit_reg;
        pidx_next  = pidx_reg;
        if (adv)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                bit_next   = pbit_reg;
                idx_next   = pidx_reg;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end
            else if (stat.valid)
            begin
                valid_next = 1'b1;
                if (head.has_a)
                begin
                    bit_next  = head.val_a;
                    idx_next  = head.idx_a;
                    last_next = ~head.has_b;
                    pend_next = head.has_b;
                    pbit_next = head.val_b;
                    pidx_next = head.idx_b;
                end
                else
                begin
                    bit_next  = head.val_b;
                    idx_next  = head.idx_b;
                    last_next = 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        pbit_reg <= pbit_next;
        pidx_reg <= pidx_next;
    end

    assign out_valid = valid_reg;
    assign out_bit   = bit_reg;
    assign out_idx   = idx_reg;
    assign out_last  = last_reg;

endmodule

FILE: src/fsk_correlator_bit_demodulator_unit.sv
// Top level of the FSK correlator bit demodulator: streams, APB register, assertions.
// Depends on fcbd_pkg, fcbd_front, fcbd_queue, fcbd_back and the assertion header.

// Takes one complex sample per clock on the slave stream and never stalls it while the
// master side keeps up; ready drops only once the four-entry job queue between the
// correlator and the output stage is full. The first two samples of each packet are
// skipped, then every fourth sample closes a window of five (windows share their edge
// sample) and yields zero, one or two bits; they pass through the job queue and leave
// one bit per clock while m_axis_tready holds. tlast on the input ends the packet and
// clears the counters. Register 0 at address 0 holds the preamble length (reset 32).
`include "fsk_correlator_bit_demodulator_unit_assert.svh"

module fsk_correlator_bit_demodulator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sample_i, [31:16] sample_q
    input  logic        s_axis_tlast,   // packet_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] bit_value, [8:1] bit_index, rest zero
    output logic        m_axis_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        pre_reg, pre_next;
    logic              s_accept;
    logic              push;
    logic              pop;
    fcbd_pkg::job_t    job;
    fcbd_pkg::job_t    head;
    fcbd_pkg::qstat_t  stat;
    logic              out_bit;
    logic [7:0]        out_idx;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == fcbd_pkg::ADDR_PREAMBLE) ? {24'd0, pre_reg} : 32'd0;

    always_comb
    begin
        pre_next = pre_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == fcbd_pkg::ADDR_PREAMBLE))
        begin
            pre_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg <= fcbd_pkg::PREAMBLE_RESET;
        end
        else
        begin
            pre_reg <= pre_next;
        end
    end

    assign s_axis_tready = ~stat.full;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    fcbd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (s_accept),
        .sample_q      (s_axis_tdata[31:16]),
        .packet_end    (s_axis_tlast),
        .preamble_bits (pre_reg),
        .push          (push),
        .job           (job)
    );

    fcbd_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    fcbd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_bit   (out_bit),
        .out_idx   (out_idx),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, out_idx, out_bit};

    `FCBD_ASSERT_MSG(a_no_overflow, push |-> !stat.full, "job pushed into full queue")
    `FCBD_ASSERT(a_job_nonempty, push |-> (job.has_a || job.has_b))
    `FCBD_ASSERT_MSG(a_pair_follows,
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tlast && (out_idx == $past(out_idx) + 8'd1)),
        "second bit of a window missing or misnumbered")

endmodule
